// ===== hw/rtl/vwc_pkg.sv =====
// Shared constants for the valid-window convolution block.
// Field widths, register indexes and parameter defaults; no dependencies.
package vwc_pkg;

    localparam int PIX_W          = 8;     // pixel and coefficient width
    localparam int PROD_W         = 16;    // coefficient x pixel
    localparam int SUM_W          = 21;    // 25 * 255 * 255 fits
    localparam int DIV_W          = 13;    // 255 * 25 fits
    localparam int NUM_COEF       = 25;
    localparam int COEF_IDX_W     = 5;
    localparam int COEF_PER_BANK  = 8;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_HEIGHT     = 1024;
    localparam int ROW_W          = 10;    // row counter, MAX_HEIGHT - 1 fits

    localparam int DIM_W          = 11;    // width / height registers
    localparam int KDIM_W         = 3;     // kernel size registers
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BANK_0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BANK_1  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BANK_2  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BANK_3  = 4'd7;

    localparam logic [DIM_W-1:0]  RST_IMAGE_DIM   = 11'd1024;
    localparam logic [KDIM_W-1:0] RST_KERNEL_DIM  = 3'd3;

endpackage

// ===== hw/rtl/vwc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the line stores of the convolution block.
module vwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/valid_window_convolution.sv =====
// Top level of the valid-window 2-D convolution: sequencer, window, shared MAC and divider.
// Depends on vwc_pkg and vwc_ram.
//
//  channel  | dir | beat contents (low bit first)
//  ---------+-----+-------------------------------------------
//  s_axis   | in  | tdata[7:0] pixel
//  m_axis   | out | tdata[7:0] out_pixel, tlast frame_last
//  cfg      | in  | cfg_we / cfg_index / cfg_data, no read-back
//
// Sequence: a pixel that completes a window goes through one line-store read, one
//   multiply-accumulate per coefficient through a single 8x8 multiplier, one drain,
//   eight restoring-division steps and one output load; any other pixel goes through
//   the line-store read only. s_axis_tready is high only between items.
// Reset: counters and registers go to their reset values at once; line stores and
//   the window are not cleared, no clearing pass.
// Stalls: the result sits in an output register; the block takes the next pixel
//   while it waits and only holds at the output load if it is still occupied.
module valid_window_convolution #(
    parameter int MAX_WIDTH  = vwc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = vwc_pkg::MAX_KERNEL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_pixel
    output logic                           m_axis_tlast,   // frame_last
    input  logic                           cfg_we,
    input  logic [vwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vwc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);          // column / line store address
    localparam int WW = $clog2(MAX_WIDTH + 1);      // clamped width
    localparam int KW = $clog2(MAX_KERNEL + 1);     // clamped kernel size
    localparam int KI = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;  // window index
    localparam int PW = vwc_pkg::PIX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // ---------------------------------------------------------------- config
    logic [vwc_pkg::DIM_W-1:0]  image_width_reg;
    logic [vwc_pkg::DIM_W-1:0]  image_height_reg;
    logic [vwc_pkg::KDIM_W-1:0] kernel_rows_reg;
    logic [vwc_pkg::KDIM_W-1:0] kernel_cols_reg;
    logic [PW-1:0]              coef_reg [vwc_pkg::NUM_COEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= vwc_pkg::RST_IMAGE_DIM;
            image_height_reg <= vwc_pkg::RST_IMAGE_DIM;
            kernel_rows_reg  <= vwc_pkg::RST_KERNEL_DIM;
            kernel_cols_reg  <= vwc_pkg::RST_KERNEL_DIM;
            for (int i = 0; i < vwc_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vwc_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg  <= cfg_data[vwc_pkg::DIM_W-1:0];
                vwc_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[vwc_pkg::DIM_W-1:0];
                vwc_pkg::CFG_KERNEL_ROWS:
                    kernel_rows_reg  <= cfg_data[vwc_pkg::KDIM_W-1:0];
                vwc_pkg::CFG_KERNEL_COLS:
                    kernel_cols_reg  <= cfg_data[vwc_pkg::KDIM_W-1:0];
                vwc_pkg::CFG_COEF_BANK_0:
                    for (int n = 0; n < vwc_pkg::COEF_PER_BANK; n++)
                    begin
                        coef_reg[n] <= cfg_data[n*PW +: PW];
                    end
                vwc_pkg::CFG_COEF_BANK_1:
                    for (int n = 0; n < vwc_pkg::COEF_PER_BANK; n++)
                    begin
                        coef_reg[vwc_pkg::COEF_PER_BANK + n] <= cfg_data[n*PW +: PW];
                    end
                vwc_pkg::CFG_COEF_BANK_2:
                    for (int n = 0; n < vwc_pkg::COEF_PER_BANK; n++)
                    begin
                        coef_reg[2*vwc_pkg::COEF_PER_BANK + n] <= cfg_data[n*PW +: PW];
                    end
                vwc_pkg::CFG_COEF_BANK_3:
                    coef_reg[vwc_pkg::NUM_COEF-1] <= cfg_data[PW-1:0];
                default:
                    ;   // unknown index: ignored
            endcase
        end
    end

    // clamped geometry; zero counts as one
    logic [WW-1:0]             w_eff;
    logic [vwc_pkg::DIM_W-1:0] h_eff;
    logic [KW-1:0]             kr_eff;
    logic [KW-1:0]             kc_eff;

    always_comb
    begin
        priority if (image_width_reg == '0)
            w_eff = WW'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width_reg);

        priority if (image_height_reg == '0)
            h_eff = vwc_pkg::DIM_W'(1);
        else if (32'(image_height_reg) > vwc_pkg::MAX_HEIGHT)
            h_eff = vwc_pkg::DIM_W'(vwc_pkg::MAX_HEIGHT);
        else
            h_eff = image_height_reg;

        priority if (kernel_rows_reg == '0)
            kr_eff = KW'(1);
        else if (32'(kernel_rows_reg) > MAX_KERNEL)
            kr_eff = KW'(MAX_KERNEL);
        else
            kr_eff = KW'(kernel_rows_reg);

        priority if (kernel_cols_reg == '0)
            kc_eff = KW'(1);
        else if (32'(kernel_cols_reg) > MAX_KERNEL)
            kc_eff = KW'(MAX_KERNEL);
        else
            kc_eff = KW'(kernel_cols_reg);
    end

    // ---------------------------------------------------------------- control
    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               col_reg, col_next;        // column of next pixel
    logic [vwc_pkg::ROW_W-1:0]   row_reg, row_next;        // row of next pixel
    logic [AW-1:0]               x_reg;                    // column of pixel at work
    logic [PW-1:0]               px_reg;
    logic                        emit_reg;
    logic                        last_reg;
    logic [vwc_pkg::DIV_W-1:0]   div_reg;

    logic                        accept;
    logic                        row_end;
    logic                        frame_end;
    logic                        emit;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign row_end   = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign frame_end = (32'(row_reg) + 32'd1) >= 32'(h_eff);
    assign emit      = (32'(col_reg) < 32'(w_eff)) && (32'(row_reg) < 32'(h_eff))
                       && ((32'(col_reg) + 32'd1) >= 32'(kc_eff))
                       && ((32'(row_reg) + 32'd1) >= 32'(kr_eff));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + vwc_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------- line stores
    // row r of the new window column: the pixel itself, then the line stores in order
    logic [PW-1:0] win_col [MAX_KERNEL];
    logic          line_we;

    assign win_col[0] = px_reg;
    assign line_we    = (state_reg == S_READ);

    for (genvar r = 1; r < MAX_KERNEL; r++)
    begin : g_line
        vwc_ram #(
            .WIDTH (PW),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (line_we),
            .waddr (x_reg),
            .wdata (win_col[r-1]),
            .re    (accept),
            .raddr (col_reg),
            .rdata (win_col[r])
        );
    end

    // window: [r][c] is r rows above and c columns left of the newest pixel
    logic [PW-1:0] win_reg [MAX_KERNEL][MAX_KERNEL];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                for (int c = MAX_KERNEL - 1; c >= 1; c--)
                begin
                    win_reg[r][c] <= win_reg[r][c-1];
                end
                win_reg[r][0] <= win_col[r];
            end
        end
    end

    // ---------------------------------------------------------------- MAC
    logic [vwc_pkg::COEF_IDX_W-1:0] k_reg;     // coefficient, row-major
    logic [KI-1:0]                  pr_reg;    // window row of this tap
    logic [KI-1:0]                  pc_reg;    // window column of this tap
    logic [vwc_pkg::PROD_W-1:0]     prod_reg;
    logic                           prod_vld_reg;
    logic [vwc_pkg::SUM_W-1:0]      acc_reg;
    logic                           mac_last;

    assign mac_last = (pr_reg == '0) && (pc_reg == '0);

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_READ:
            begin
                k_reg        <= '0;
                pr_reg       <= KI'(kr_eff - KW'(1));
                pc_reg       <= KI'(kc_eff - KW'(1));
                acc_reg      <= '0;
                prod_vld_reg <= 1'b0;
            end
            S_MAC:
            begin
                prod_reg     <= vwc_pkg::PROD_W'(coef_reg[k_reg])
                                * vwc_pkg::PROD_W'(win_reg[pr_reg][pc_reg]);
                prod_vld_reg <= 1'b1;
                if (prod_vld_reg)
                begin
                    acc_reg <= acc_reg + vwc_pkg::SUM_W'(prod_reg);
                end
                k_reg <= k_reg + vwc_pkg::COEF_IDX_W'(1);
                if (pc_reg == '0)
                begin
                    pc_reg <= KI'(kc_eff - KW'(1));
                    pr_reg <= pr_reg - KI'(1);
                end
                else
                begin
                    pc_reg <= pc_reg - KI'(1);
                end
            end
            default:
                ;
        endcase
    end

    // ---------------------------------------------------------------- divider
    // restoring division, one quotient bit a step; the quotient never exceeds 255
    logic [vwc_pkg::SUM_W-1:0] rem_reg;
    logic [vwc_pkg::SUM_W-1:0] dsh_reg;
    logic [PW-1:0]             quo_reg;
    logic [2:0]                step_reg;
    logic                      fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_DRAIN:
            begin
                rem_reg  <= acc_reg + vwc_pkg::SUM_W'(prod_reg);
                dsh_reg  <= vwc_pkg::SUM_W'({div_reg, 7'b0});
                step_reg <= '0;
            end
            S_DIV:
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg  <= {quo_reg[PW-2:0], fits};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg + 3'd1;
            end
            default:
                ;
        endcase
    end

    // ---------------------------------------------------------------- output
    logic          out_vld_reg, out_vld_next;
    logic [PW-1:0] out_data_reg;
    logic          out_last_reg;
    logic          out_load;

    assign out_load = (state_reg == S_DONE) && (!out_vld_reg || m_axis_tready);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= quo_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = emit_reg ? S_MAC : S_IDLE;
            S_MAC:   if (mac_last) state_next = S_DRAIN;
            S_DRAIN: state_next = S_DIV;
            S_DIV:   if (step_reg == 3'd7) state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            emit_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            out_vld_reg <= out_vld_next;
            if (accept)
            begin
                emit_reg <= emit;
            end
        end
    end

    // item payload, captured on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= s_axis_tdata;
            x_reg    <= col_reg;
            last_reg <= row_end && frame_end;
            div_reg  <= vwc_pkg::DIV_W'(32'(kr_eff) * 32'(kc_eff) * 255);
        end
    end

endmodule
